FILE: rtl/core/mavg_pkg.sv
// shared widths, register indexes and scaling constants for the moving average pwm block
`default_nettype none

package mavg_pkg;

    // sample and average width
    localparam int SAMPLE_W = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

    // demand that maps to full duty
    localparam int FULL_SCALE   = 1000;
    localparam int FULL_SCALE_W = 10;

    // magnitudes at or above this cap saturate the duty for any pwm top
    localparam int CLAMP_W = 11;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

`default_nettype wire

FILE: rtl/core/moving_average_hbridge_pwm.sv
// boxcar moving average of pwm-period samples mapped to h-bridge compare values
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------------
//  in       | in        | in_valid / in_ready   | sample
//  out      | out       | out_valid / out_ready | forward_duty, reverse_duty, filtered_level
//  cfg      | in        | cfg_write             | cfg_index, cfg_data
//
//  a running transaction passes the ring update and the load step, then the divider for
//  sum/length, which yields one quotient bit per cycle, then the pwm_top product and the
//  reciprocal multiply that scales by 1/1000
//  a transaction taken while stopped goes straight to the output step and changes no state
//  in_ready is high only while idle; a finished result waits in the output register, so the
//  next transaction is taken while the previous result is still unclaimed
//  reset and a window_length write clear sum and pointer; the ring needs no clearing pass,
//  entries read before the pointer first wraps count as zero
`default_nettype none

module moving_average_hbridge_pwm #(
    parameter int MAX_TAPS = 1024,
    parameter int PWM_TOP  = 4095
) (
    input  wire                                   clk,
    input  wire                                   rst_n,

    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire  signed [mavg_pkg::SAMPLE_W-1:0]  sample,

    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [$clog2(PWM_TOP+1)-1:0]          forward_duty,
    output logic [$clog2(PWM_TOP+1)-1:0]          reverse_duty,
    output logic signed [mavg_pkg::SAMPLE_W-1:0]  filtered_level,

    input  wire                                   cfg_write,
    input  wire  [mavg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [$clog2(MAX_TAPS+1)-1:0]         cfg_data
);

    localparam int DUTY_W  = $clog2(PWM_TOP + 1);
    localparam int LEN_W   = $clog2(MAX_TAPS + 1);
    localparam int PTR_W   = $clog2(MAX_TAPS);
    localparam int SUM_W   = mavg_pkg::SAMPLE_W + PTR_W + 1;
    localparam int PROD_W  = mavg_pkg::CLAMP_W + DUTY_W;
    localparam int DIV_W   = (SUM_W - 1 > PROD_W) ? SUM_W - 1 : PROD_W;
    localparam int DVS_W   = (LEN_W > mavg_pkg::FULL_SCALE_W) ? LEN_W : mavg_pkg::FULL_SCALE_W;
    localparam int CNT_W   = $clog2(DIV_W);
    // reciprocal of the full scale, exact for every product below 2^PROD_W
    localparam int RCP_K   = PROD_W + mavg_pkg::FULL_SCALE_W;
    localparam int RCP_W   = PROD_W + 1;
    localparam int RPROD_W = PROD_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'(((64'd1 << RCP_K) + 64'(mavg_pkg::FULL_SCALE) - 64'd1)
               / 64'(mavg_pkg::FULL_SCALE));

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_SCL  = 3'd6;

    // control state
    logic [2:0]              state_reg, state_next;
    logic                    run_reg, run_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [PTR_W-1:0]        pos_reg, pos_next;
    logic                    wrapped_reg, wrapped_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    stop_reg, stop_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // datapath
    mavg_pkg::sample_t       sample_reg;
    mavg_pkg::sample_t       ring_rd_reg;
    logic                    neg_reg;
    logic [DIV_W-1:0]        dvd_reg, dvd_next;
    logic [DVS_W-1:0]        dvs_reg, dvs_next;
    logic [DVS_W-1:0]        rem_reg, rem_next;
    mavg_pkg::sample_t       level_reg, level_next;
    logic [DUTY_W-1:0]       fwd_reg, fwd_next;
    logic [DUTY_W-1:0]       rev_reg, rev_next;
    mavg_pkg::sample_t       lvl_out_reg, lvl_out_next;

    // sample ring, one write and one registered read port
    mavg_pkg::sample_t       ring_mem [MAX_TAPS];

    logic                    in_fire;
    logic                    ring_we;
    logic [LEN_W-1:0]        pos_inc;
    mavg_pkg::sample_t       old_sample;
    logic [DVS_W:0]          rem_shift;
    logic                    rem_ge;
    logic [mavg_pkg::CLAMP_W-1:0] mag_clamp;
    logic [PROD_W-1:0]       product;
    logic [RPROD_W-1:0]      rcp_prod;
    logic [LEN_W-1:0]        len_clamped;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign forward_duty   = fwd_reg;
    assign reverse_duty   = rev_reg;
    assign filtered_level = lvl_out_reg;

    assign ring_we    = (state_reg == S_UPD);
    assign pos_inc    = LEN_W'(pos_reg) + LEN_W'(1);
    // entries not yet rewritten since the last clear count as zero
    assign old_sample = wrapped_reg ? ring_rd_reg : '0;

    // one restoring step
    assign rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dvs_reg});

    // any magnitude past the cap saturates, so the product stays narrow
    assign mag_clamp = (|dvd_reg[DIV_W-1:mavg_pkg::CLAMP_W])
                       ? {mavg_pkg::CLAMP_W{1'b1}} : dvd_reg[mavg_pkg::CLAMP_W-1:0];
    assign product   = PROD_W'(mag_clamp) * PROD_W'(PWM_TOP);

    // product / 1000 as a multiply by the scaled reciprocal
    assign rcp_prod  = RPROD_W'(dvd_reg[PROD_W-1:0]) * RPROD_W'(RCP_M);

    // length write clamps into 1..MAX_TAPS
    always_comb
    begin
        if (cfg_data == '0)
            len_clamped = LEN_W'(1);
        else if (cfg_data > LEN_W'(MAX_TAPS))
            len_clamped = LEN_W'(MAX_TAPS);
        else
            len_clamped = cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[pos_reg] <= sample_reg;
        if (in_fire)
            ring_rd_reg <= ring_mem[pos_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        run_next       = run_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        wrapped_next   = wrapped_reg;
        sum_next       = sum_reg;
        stop_next      = stop_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        level_next     = level_reg;
        fwd_next       = fwd_reg;
        rev_next       = rev_reg;
        lvl_out_next   = lvl_out_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // the user must write configuration only while idle; the block itself does not enforce it
        if (cfg_write)
        begin
            unique case (cfg_index)
                mavg_pkg::REG_RUN_ENABLE:
                    run_next = cfg_data[0];
                mavg_pkg::REG_WINDOW_LENGTH:
                begin
                    len_next     = len_clamped;
                    pos_next     = '0;
                    wrapped_next = 1'b0;
                    sum_next     = '0;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    stop_next  = !run_reg;
                    state_next = run_reg ? S_UPD : S_FIN;
                end
            end
            S_UPD:
            begin
                // oldest sample leaves, new one enters
                sum_next = sum_reg + SUM_W'(sample_reg) - SUM_W'(old_sample);
                if (pos_inc == len_reg)
                begin
                    pos_next     = '0;
                    wrapped_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_inc[PTR_W-1:0];
                end
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                dvd_next   = sum_reg[SUM_W-1] ? DIV_W'(-sum_reg) : DIV_W'(sum_reg);
                dvs_next   = DVS_W'(len_reg);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = rem_ge ? DVS_W'(rem_shift - {1'b0, dvs_reg}) : rem_shift[DVS_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], rem_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                // quotient magnitude fits the sample width, truncation toward zero
                level_next = neg_reg ? -mavg_pkg::sample_t'(dvd_reg[mavg_pkg::SAMPLE_W-1:0])
                                     : mavg_pkg::sample_t'(dvd_reg[mavg_pkg::SAMPLE_W-1:0]);
                dvd_next   = DIV_W'(product);
                state_next = S_SCL;
            end
            S_SCL:
            begin
                dvd_next   = DIV_W'(rcp_prod[RPROD_W-1:RCP_K]);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (stop_reg)
                    begin
                        fwd_next     = '0;
                        rev_next     = '0;
                        lvl_out_next = '0;
                    end
                    else
                    begin
                        logic [DUTY_W-1:0] duty;
                        duty = (dvd_reg > DIV_W'(PWM_TOP)) ? DUTY_W'(PWM_TOP)
                                                           : dvd_reg[DUTY_W-1:0];
                        fwd_next     = neg_reg ? '0 : duty;
                        rev_next     = neg_reg ? duty : '0;
                        lvl_out_next = level_reg;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_reg       <= 1'b0;
            len_reg       <= LEN_W'(1);
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            sum_reg       <= '0;
            stop_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            wrapped_reg   <= wrapped_next;
            sum_reg       <= sum_next;
            stop_reg      <= stop_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
            sample_reg <= sample;
        if (state_reg == S_LOAD)
            neg_reg <= sum_reg[SUM_W-1];
        dvd_reg     <= dvd_next;
        dvs_reg     <= dvs_next;
        rem_reg     <= rem_next;
        level_reg   <= level_next;
        fwd_reg     <= fwd_next;
        rev_reg     <= rev_next;
        lvl_out_reg <= lvl_out_next;
    end

endmodule

`default_nettype wire
